>>> design/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg: shared definitions for the selective-repeat sender window
// Field widths, event and result codes, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srsw_pkg;

	localparam int WINDOW_MAX_DEF = 32;

	localparam int SEQ_W        = 31;
	localparam int BITMAP_W     = 32;
	localparam int BITMAP_IDX_W = $clog2(BITMAP_W);
	localparam int WSIZE_W      = 6;
	localparam int RETRY_W      = 4;
	localparam int OP_W         = 2;
	localparam int KIND_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 31;

	localparam logic [WSIZE_W-1:0] WSIZE_RST = 6'd4;
	localparam logic [SEQ_W-1:0]   LAST_RST  = 31'd1;
	localparam logic [RETRY_W-1:0] RETRY_RST = 4'd3;

	typedef enum logic [OP_W-1:0] {
		OP_START   = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEND  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_SIZE = 2'd0,
		CFG_LAST_SEQ    = 2'd1,
		CFG_RETRY_LIMIT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic flush;
	} srsw_cmd_t;

	typedef struct packed {
		logic loop_done;
		logic cand_emit;
		logic pend_valid;
		logic out_free;
	} srsw_stat_t;

endpackage

>>> design/srsw_if.sv
// ----------------------------------------------------------------------------
// srsw_if: channel interfaces of the selective-repeat sender window
// Event input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface srsw_req_if;
	logic                              valid;
	logic                              ready;
	logic [srsw_pkg::OP_W-1:0]         opcode;
	logic [srsw_pkg::SEQ_W-1:0]        ack_seq;
	logic [srsw_pkg::BITMAP_W-1:0]     ack_bitmap;

	modport source (output valid, output opcode, output ack_seq, output ack_bitmap,
		input ready);
	modport sink (input valid, input opcode, input ack_seq, input ack_bitmap,
		output ready);
endinterface

interface srsw_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [srsw_pkg::KIND_W-1:0]       kind;
	logic [srsw_pkg::SEQ_W-1:0]        send_seq;
	logic                              last_of_run;

	modport source (output valid, output kind, output send_seq, output last_of_run,
		input ready);
	modport sink (input valid, input kind, input send_seq, input last_of_run,
		output ready);
endinterface

interface srsw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [srsw_pkg::CFG_IDX_W-1:0]    index;
	logic [srsw_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender window of a selective-repeat transfer
// Answers start, ack and timeout events with runs of send requests, with a
// single done or abort beat, or with nothing; each run's final beat is marked.
// ----------------------------------------------------------------------------
// One event at a time. An event is accepted, then the walk visits one window
// position per step (up to the effective window size, 32 at most, and cut
// short at the last sequence), then the end of the walk is seen and the final
// beat is released. A start or a timeout walks the window size, an ack walks
// the slide length, and an event with no result or a single done or abort
// beat walks nothing. The walk steps one position per cycle, advancing a
// position counter and a sequence counter together; a stalled result channel
// holds the walk. Configuration writes are always taken.
module selective_repeat_sender_window #(
	parameter int WINDOW_MAX = srsw_pkg::WINDOW_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	srsw_cfg_if.sink   cfg,
	srsw_req_if.sink   req,
	srsw_rsp_if.source rsp
);
	import srsw_pkg::*;

	srsw_cmd_t  cmd;
	srsw_stat_t stat;

	assign cfg.ready = 1'b1;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srsw_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.opcode      (req.opcode),
		.ack_seq     (req.ack_seq),
		.ack_bitmap  (req.ack_bitmap),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.kind        (rsp.kind),
		.send_seq    (rsp.send_seq),
		.last_of_run (rsp.last_of_run),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

>>> design/srsw_datapath.sv
// ----------------------------------------------------------------------------
// srsw_datapath: window state, walk counter and result registers
// Holds the configuration and window state, walks the window one position
// per step, and passes results through a pending slot into the output beat.
// ----------------------------------------------------------------------------
module srsw_datapath #(
	parameter int WINDOW_MAX = srsw_pkg::WINDOW_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [srsw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [srsw_pkg::OP_W-1:0]         opcode,
	input  logic [srsw_pkg::SEQ_W-1:0]        ack_seq,
	input  logic [srsw_pkg::BITMAP_W-1:0]     ack_bitmap,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [srsw_pkg::KIND_W-1:0]       kind,
	output logic [srsw_pkg::SEQ_W-1:0]        send_seq,
	output logic                              last_of_run,
	input  srsw_pkg::srsw_cmd_t               cmd,
	output srsw_pkg::srsw_stat_t              stat
);
	import srsw_pkg::*;

	localparam int WIN_CAP = (WINDOW_MAX < BITMAP_W) ? WINDOW_MAX : BITMAP_W;
	localparam int CNT_W   = $clog2(WIN_CAP + 1);

	typedef enum logic [1:0] {
		MODE_NEW,
		MODE_SLIDE,
		MODE_RESEND
	} mode_t;

	logic [WSIZE_W-1:0]   wsize_q;
	logic [SEQ_W-1:0]     last_q;
	logic [RETRY_W-1:0]   rlimit_q;

	logic [SEQ_W-1:0]     base_q;
	logic [SEQ_W:0]       next_q;
	logic [RETRY_W-1:0]   retries_q;
	logic [BITMAP_W-1:0]  bits_q;
	logic                 active_q;

	mode_t                mode_q;
	logic [CNT_W-1:0]     j_q;
	logic [CNT_W-1:0]     lim_q;
	logic [SEQ_W:0]       cur_q;

	logic                 pend_valid_q;
	kind_t                pend_kind_q;
	logic [SEQ_W-1:0]     pend_seq_q;

	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [SEQ_W-1:0]     out_seq_q;
	logic                 out_last_q;

	logic [CNT_W-1:0]        win;
	logic [SEQ_W-1:0]        jumps;
	logic [CNT_W-1:0]        slide_lim;
	logic [RETRY_W-1:0]      retry_dec;
	logic [BITMAP_IDX_W-1:0] bit_idx;
	logic                    move;

	always_comb begin
		if (wsize_q == '0) begin
			win = CNT_W'(1);
		end else if (32'(wsize_q) > WIN_CAP) begin
			win = CNT_W'(WIN_CAP);
		end else begin
			win = CNT_W'(wsize_q);
		end
	end

	assign jumps     = ack_seq - base_q;
	assign slide_lim = (jumps > SEQ_W'(win)) ? win : CNT_W'(jumps);
	assign retry_dec = (retries_q != '0) ? retries_q - RETRY_W'(1) : '0;
	assign bit_idx   = BITMAP_IDX_W'(j_q);

	assign stat.loop_done  = (j_q == lim_q) || (cur_q > {1'b0, last_q});
	assign stat.cand_emit  = (mode_q != MODE_RESEND) || !bits_q[bit_idx];
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign move = (cmd.step && stat.cand_emit && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q      <= WSIZE_RST;
			last_q       <= LAST_RST;
			rlimit_q     <= RETRY_RST;
			base_q       <= SEQ_W'(1);
			next_q       <= (SEQ_W + 1)'(WSIZE_RST) + (SEQ_W + 1)'(1);
			retries_q    <= RETRY_RST;
			bits_q       <= '0;
			active_q     <= 1'b0;
			mode_q       <= MODE_NEW;
			j_q          <= '0;
			lim_q        <= '0;
			cur_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_SIZE: wsize_q  <= cfg_data[WSIZE_W-1:0];
					CFG_LAST_SEQ:    last_q   <= cfg_data[SEQ_W-1:0];
					CFG_RETRY_LIMIT: rlimit_q <= cfg_data[RETRY_W-1:0];
					default: ;
				endcase
			end

			if (cmd.accept) begin
				j_q <= '0;
				unique case (opcode_t'(opcode))
					OP_START: begin
						base_q       <= SEQ_W'(1);
						next_q       <= (SEQ_W + 1)'(win) + (SEQ_W + 1)'(1);
						retries_q    <= rlimit_q;
						bits_q       <= '0;
						active_q     <= 1'b1;
						mode_q       <= MODE_NEW;
						cur_q        <= (SEQ_W + 1)'(1);
						lim_q        <= win;
						pend_valid_q <= 1'b0;
					end
					OP_ACK: begin
						if (active_q) begin
							bits_q    <= ack_bitmap;
							retries_q <= rlimit_q;
							if (ack_seq > base_q) begin
								base_q <= ack_seq;
								if (ack_seq > last_q) begin
									active_q     <= 1'b0;
									pend_valid_q <= 1'b1;
									lim_q        <= '0;
								end else begin
									mode_q       <= MODE_SLIDE;
									cur_q        <= next_q;
									lim_q        <= slide_lim;
									pend_valid_q <= 1'b0;
								end
							end else begin
								lim_q        <= '0;
								pend_valid_q <= 1'b0;
							end
						end else begin
							lim_q        <= '0;
							pend_valid_q <= 1'b0;
						end
					end
					OP_TIMEOUT: begin
						if (active_q) begin
							retries_q <= retry_dec;
							if (retry_dec == '0) begin
								active_q     <= 1'b0;
								pend_valid_q <= 1'b1;
								lim_q        <= '0;
							end else begin
								mode_q       <= MODE_RESEND;
								cur_q        <= {1'b0, base_q};
								lim_q        <= win;
								pend_valid_q <= 1'b0;
							end
						end else begin
							lim_q        <= '0;
							pend_valid_q <= 1'b0;
						end
					end
					default: begin
						lim_q        <= '0;
						pend_valid_q <= 1'b0;
					end
				endcase
			end else if (cmd.step) begin
				j_q   <= j_q + CNT_W'(1);
				cur_q <= cur_q + (SEQ_W + 1)'(1);
				if (mode_q == MODE_SLIDE) begin
					next_q <= cur_q + (SEQ_W + 1)'(1);
				end
				if (stat.cand_emit) begin
					pend_valid_q <= 1'b1;
				end
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_kind_q <= (opcode_t'(opcode) == OP_ACK) ? KIND_DONE : KIND_ABORT;
			pend_seq_q  <= '0;
		end else if (cmd.step && stat.cand_emit) begin
			pend_kind_q <= KIND_SEND;
			pend_seq_q  <= cur_q[SEQ_W-1:0];
		end
		if (move) begin
			out_kind_q <= pend_kind_q;
			out_seq_q  <= pend_seq_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign send_seq    = out_seq_q;
	assign last_of_run = out_last_q;

endmodule

>>> design/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl: event sequencer of the selective-repeat sender window
// Takes one event, steps the window walk while the result path has room,
// then closes the run by releasing the held result as the final beat.
// ----------------------------------------------------------------------------
module srsw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srsw_pkg::srsw_stat_t stat,
	output srsw_pkg::srsw_cmd_t  cmd
);
	import srsw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready   = ready_q;
	assign cmd.accept = ready_q && in_valid;
	assign cmd.step   = (state_q == ST_RUN) && !stat.loop_done
		&& !(stat.cand_emit && stat.pend_valid && !stat.out_free);
	assign cmd.flush  = (state_q == ST_FLUSH) && stat.pend_valid && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_RUN;
						ready_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (stat.loop_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!stat.pend_valid || stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule
